// ===== rtl/akf_pkg.sv =====
// shared types, constants, micro-program and saturation helpers of the altitude filter
`default_nettype none
package akf_pkg;

   localparam int WORD_W  = 48;
   localparam int SHIFT_W = 5;
   localparam int PC_W    = 6;

   typedef logic signed [WORD_W-1:0] word_type;
   typedef logic signed [WORD_W:0]   wide_type;
   typedef logic [PC_W-1:0]          pc_type;

   localparam word_type MAX48 = {1'b0, {(WORD_W-1){1'b1}}};

   localparam logic [1:0] CMD_PREDICT = 2'd0;
   localparam logic [1:0] CMD_UPDATE  = 2'd1;
   localparam logic [1:0] CMD_RESET   = 2'd2;
   localparam logic [1:0] CMD_UNUSED  = 2'd3;

   localparam logic CSR_MEAS_VAR  = 1'b0;
   localparam logic CSR_ACCEL_VAR = 1'b1;

   localparam logic [31:0] MEAS_VAR_RESET  = 32'd102400;
   localparam logic [31:0] ACCEL_VAR_RESET = 32'd256000;
   localparam int          VAR_RESET_INT   = 1500;

   localparam int FRACTION_BITS_DEFAULT = 16;

   typedef enum logic [4:0] {
      SRC_ALT, SRC_SPD, SRC_PZZ, SRC_PZV, SRC_PVV,
      SRC_DT, SRC_QA, SRC_DT2, SRC_DT3, SRC_DT4,
      SRC_T, SRC_TMP, SRC_R, SRC_Y, SRC_KZ, SRC_KV,
      SRC_ALTF, SRC_OFA, SRC_OFV,
      SRC_ACC, SRC_MEAS, SRC_TS, SRC_ALTIN, SRC_ONE, SRC_C256
   } src_type;

   typedef enum logic [2:0] {
      OP_MUL, OP_ADD, OP_SUB, OP_SUM, OP_CHK, OP_DIV, OP_EMIT, OP_END
   } op_type;

   typedef enum logic [1:0] {
      SH_ZERO, SH_EIGHT, SH_SIXTEEN, SH_FRAC
   } sh_type;

   typedef struct packed {
      op_type     op;
      src_type    a;
      src_type    b;
      src_type    dst;
      sh_type     sh;
      logic [1:0] bsh;
   } uop_type;

   localparam pc_type PC_PREDICT = 6'd0;
   localparam pc_type PC_UPDATE  = 6'd21;
   localparam pc_type PC_OUTPUT  = 6'd38;

   function automatic uop_type mk(op_type op, src_type a, src_type b, src_type dst,
                                  sh_type sh, logic [1:0] bsh);
      uop_type u;
      u.op  = op;
      u.a   = a;
      u.b   = b;
      u.dst = dst;
      u.sh  = sh;
      u.bsh = bsh;
      return u;
   endfunction

   function automatic uop_type uop(pc_type pc);
      uop_type u;
      unique case (pc)
         // predict
         6'd0:  u = mk(OP_MUL, SRC_TS,   SRC_ONE,  SRC_DT,   SH_SIXTEEN, 2'd0);
         6'd1:  u = mk(OP_MUL, SRC_ACC,  SRC_ONE,  SRC_QA,   SH_EIGHT,   2'd0);
         6'd2:  u = mk(OP_MUL, SRC_DT,   SRC_DT,   SRC_DT2,  SH_FRAC,    2'd0);
         6'd3:  u = mk(OP_MUL, SRC_DT2,  SRC_DT,   SRC_DT3,  SH_FRAC,    2'd0);
         6'd4:  u = mk(OP_MUL, SRC_DT2,  SRC_DT2,  SRC_DT4,  SH_FRAC,    2'd0);
         6'd5:  u = mk(OP_MUL, SRC_DT,   SRC_PZV,  SRC_T,    SH_FRAC,    2'd0);
         6'd6:  u = mk(OP_MUL, SRC_SPD,  SRC_DT,   SRC_TMP,  SH_FRAC,    2'd0);
         6'd7:  u = mk(OP_ADD, SRC_ALT,  SRC_TMP,  SRC_ALT,  SH_ZERO,    2'd0);
         6'd8:  u = mk(OP_ADD, SRC_PZZ,  SRC_T,    SRC_PZZ,  SH_ZERO,    2'd0);
         6'd9:  u = mk(OP_ADD, SRC_PZZ,  SRC_T,    SRC_PZZ,  SH_ZERO,    2'd0);
         6'd10: u = mk(OP_MUL, SRC_DT2,  SRC_PVV,  SRC_TMP,  SH_FRAC,    2'd0);
         6'd11: u = mk(OP_ADD, SRC_PZZ,  SRC_TMP,  SRC_PZZ,  SH_ZERO,    2'd0);
         6'd12: u = mk(OP_MUL, SRC_QA,   SRC_DT4,  SRC_TMP,  SH_FRAC,    2'd0);
         6'd13: u = mk(OP_ADD, SRC_PZZ,  SRC_TMP,  SRC_PZZ,  SH_ZERO,    2'd2);
         6'd14: u = mk(OP_MUL, SRC_DT,   SRC_PVV,  SRC_TMP,  SH_FRAC,    2'd0);
         6'd15: u = mk(OP_ADD, SRC_PZV,  SRC_TMP,  SRC_PZV,  SH_ZERO,    2'd0);
         6'd16: u = mk(OP_MUL, SRC_QA,   SRC_DT3,  SRC_TMP,  SH_FRAC,    2'd0);
         6'd17: u = mk(OP_ADD, SRC_PZV,  SRC_TMP,  SRC_PZV,  SH_ZERO,    2'd1);
         6'd18: u = mk(OP_MUL, SRC_QA,   SRC_DT2,  SRC_TMP,  SH_FRAC,    2'd0);
         6'd19: u = mk(OP_ADD, SRC_PVV,  SRC_TMP,  SRC_PVV,  SH_ZERO,    2'd0);
         6'd20: u = mk(OP_END, SRC_ALT,  SRC_ALT,  SRC_ALT,  SH_ZERO,    2'd0);
         // update
         6'd21: u = mk(OP_MUL, SRC_MEAS, SRC_ONE,  SRC_R,    SH_EIGHT,   2'd0);
         6'd22: u = mk(OP_SUM, SRC_PZZ,  SRC_R,    SRC_R,    SH_ZERO,    2'd0);
         6'd23: u = mk(OP_CHK, SRC_ALT,  SRC_ALT,  SRC_ALT,  SH_ZERO,    2'd0);
         6'd24: u = mk(OP_MUL, SRC_ALTIN,SRC_ONE,  SRC_ALTF, SH_ZERO,    2'd0);
         6'd25: u = mk(OP_SUB, SRC_ALTF, SRC_ALT,  SRC_Y,    SH_ZERO,    2'd0);
         6'd26: u = mk(OP_DIV, SRC_PZZ,  SRC_PZZ,  SRC_KZ,   SH_ZERO,    2'd0);
         6'd27: u = mk(OP_DIV, SRC_PZV,  SRC_PZV,  SRC_KV,   SH_ZERO,    2'd0);
         6'd28: u = mk(OP_MUL, SRC_KZ,   SRC_Y,    SRC_TMP,  SH_FRAC,    2'd0);
         6'd29: u = mk(OP_ADD, SRC_ALT,  SRC_TMP,  SRC_ALT,  SH_ZERO,    2'd0);
         6'd30: u = mk(OP_MUL, SRC_KV,   SRC_Y,    SRC_TMP,  SH_FRAC,    2'd0);
         6'd31: u = mk(OP_ADD, SRC_SPD,  SRC_TMP,  SRC_SPD,  SH_ZERO,    2'd0);
         6'd32: u = mk(OP_MUL, SRC_PZV,  SRC_KV,   SRC_TMP,  SH_FRAC,    2'd0);
         6'd33: u = mk(OP_SUB, SRC_PVV,  SRC_TMP,  SRC_PVV,  SH_ZERO,    2'd0);
         6'd34: u = mk(OP_MUL, SRC_PZV,  SRC_KZ,   SRC_TMP,  SH_FRAC,    2'd0);
         6'd35: u = mk(OP_SUB, SRC_PZV,  SRC_TMP,  SRC_PZV,  SH_ZERO,    2'd0);
         6'd36: u = mk(OP_MUL, SRC_PZZ,  SRC_KZ,   SRC_TMP,  SH_FRAC,    2'd0);
         6'd37: u = mk(OP_SUB, SRC_PZZ,  SRC_TMP,  SRC_PZZ,  SH_ZERO,    2'd0);
         // output scaling
         6'd38: u = mk(OP_MUL, SRC_ALT,  SRC_C256, SRC_OFA,  SH_FRAC,    2'd0);
         6'd39: u = mk(OP_MUL, SRC_SPD,  SRC_C256, SRC_OFV,  SH_FRAC,    2'd0);
         6'd40: u = mk(OP_EMIT, SRC_ALT, SRC_ALT,  SRC_ALT,  SH_ZERO,    2'd0);
         default: u = mk(OP_END, SRC_ALT, SRC_ALT, SRC_ALT,  SH_ZERO,    2'd0);
      endcase
      return u;
   endfunction

   function automatic word_type sat48(wide_type x);
      wide_type hi;
      wide_type lo;
      hi = {1'b0, MAX48};
      lo = -hi;
      if (x > hi) return MAX48;
      else if (x < lo) return -MAX48;
      else return x[WORD_W-1:0];
   endfunction

   function automatic logic [WORD_W-1:0] mag(word_type x);
      return x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
   endfunction

endpackage
`default_nettype wire

// ===== rtl/akf_mul.sv =====
// shared signed multiplier: 48x48 magnitudes in four 24x24 partial products, shift, saturate
`default_nettype none
module akf_mul (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           start,
   input  wire akf_pkg::word_type              op_a,
   input  wire akf_pkg::word_type              op_b,
   input  wire logic [akf_pkg::SHIFT_W-1:0]    shift,
   output logic                                done,
   output akf_pkg::word_type                   product
);
   import akf_pkg::*;

   localparam int HALF_W = WORD_W / 2;
   localparam int ACC_W  = 2 * WORD_W;

   logic [WORD_W-1:0]  ua_ff, ua_in;
   logic [WORD_W-1:0]  ub_ff, ub_in;
   logic               neg_ff, neg_in;
   logic [SHIFT_W-1:0] sh_ff, sh_in;
   logic [ACC_W-1:0]   acc_ff, acc_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   word_type           prod_ff, prod_in;

   logic [HALF_W-1:0]  pa;
   logic [HALF_W-1:0]  pb;
   logic [WORD_W-1:0]  pp;
   logic [ACC_W-1:0]   pp_pos;
   logic [ACC_W-1:0]   shifted;
   logic [WORD_W-2:0]  mag_r;

   always_comb begin
      pa      = cnt_ff[1] ? ua_ff[WORD_W-1:HALF_W] : ua_ff[HALF_W-1:0];
      pb      = cnt_ff[0] ? ub_ff[WORD_W-1:HALF_W] : ub_ff[HALF_W-1:0];
      pp      = pa * pb;
      unique case (cnt_ff[1:0])
         2'd0:    pp_pos = ACC_W'(pp);
         2'd3:    pp_pos = ACC_W'(pp) << WORD_W;
         default: pp_pos = ACC_W'(pp) << HALF_W;
      endcase
      shifted = acc_ff >> sh_ff;
      mag_r   = (|shifted[ACC_W-1:WORD_W-1]) ? MAX48[WORD_W-2:0] : shifted[WORD_W-2:0];

      ua_in   = ua_ff;
      ub_in   = ub_ff;
      neg_in  = neg_ff;
      sh_in   = sh_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod_in = prod_ff;
      if (start) begin
         ua_in   = mag(op_a);
         ub_in   = mag(op_b);
         neg_in  = op_a[WORD_W-1] ^ op_b[WORD_W-1];
         sh_in   = shift;
         acc_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff[2]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            prod_in = neg_ff ? -word_type'({1'b0, mag_r}) : word_type'({1'b0, mag_r});
         end else begin
            acc_in = acc_ff + pp_pos;
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ua_ff   <= ua_in;
      ub_ff   <= ub_in;
      neg_ff  <= neg_in;
      sh_ff   <= sh_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign done    = done_ff;
   assign product = prod_ff;

endmodule
`default_nettype wire

// ===== rtl/akf_div.sv =====
// restoring divider for the gain: (|num| << FRACTION_BITS) / den, one bit a cycle, saturated
`default_nettype none
module akf_div #(
   parameter int FRACTION_BITS = akf_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire akf_pkg::word_type  num,
   input  wire akf_pkg::wide_type  den,
   output logic                    done,
   output akf_pkg::word_type       quotient
);
   import akf_pkg::*;

   localparam int N_BITS = WORD_W + FRACTION_BITS;
   localparam int CNT_W  = $clog2(N_BITS + 1);
   localparam int REM_W  = WORD_W + 2;

   logic [N_BITS-1:0] qd_ff, qd_in;
   logic [REM_W-2:0]  rem_ff, rem_in;
   logic [WORD_W:0]   den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   word_type          quo_ff, quo_in;

   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  rem_sub;
   logic              take;
   logic [WORD_W-2:0] mag_q;

   always_comb begin
      rem_sh  = {rem_ff, qd_ff[N_BITS-1]};
      rem_sub = rem_sh - REM_W'(den_ff);
      take    = rem_sh >= REM_W'(den_ff);
      mag_q   = (|qd_ff[N_BITS-1:WORD_W-1]) ? MAX48[WORD_W-2:0] : qd_ff[WORD_W-2:0];

      qd_in   = qd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      quo_in  = quo_ff;
      if (start) begin
         qd_in   = {mag(num), {FRACTION_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = den;
         neg_in  = num[WORD_W-1];
         cnt_in  = CNT_W'(N_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            quo_in  = neg_ff ? -word_type'({1'b0, mag_q}) : word_type'({1'b0, mag_q});
         end else begin
            // remainder stays below den, so it fits one bit under the compare width
            rem_in = take ? rem_sub[REM_W-2:0] : rem_sh[REM_W-2:0];
            qd_in  = {qd_ff[N_BITS-2:0], take};
            cnt_in = cnt_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      qd_ff  <= qd_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== rtl/altitude_velocity_kalman_filter_unit.sv =====
// top level of the altitude and vertical speed filter: sequencer, state and shared units
//
//  channel  direction  handshake            payload
//  req      in         req_tvalid/tready    tuser: command; tdata: altitude_cm, time_step
//  rsp      out        rsp_tvalid/tready    tdata: filtered_altitude, vertical_speed
//  csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// a reset command is applied as it is accepted; a predict and an update run their
// micro-programs, each multiply in the shared multiplier and each of the two gain
// divisions in the bit-serial divider.
// req_tready is low while a command runs; a result waits in the output register and
// the next item is taken meanwhile, only the emit step waits for rsp_tready.
// reset clears control state and the estimates, and loads the covariance and the CSR registers with their reset values.
`default_nettype none
module altitude_velocity_kalman_filter_unit #(
   parameter int FRACTION_BITS = akf_pkg::FRACTION_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [1:0]  req_tuser,   // command
   input  wire logic [39:0] req_tdata,   // altitude_cm [20:0], time_step [36:21]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // filtered_altitude [31:0], vertical_speed [55:32]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_wdata
);
   import akf_pkg::*;

   localparam word_type ONE_C     = word_type'(1) <<< FRACTION_BITS;
   localparam word_type C256      = word_type'(256);
   localparam word_type VAR_RESET = word_type'(VAR_RESET_INT) <<< FRACTION_BITS;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_RUN  = 3'b010,
      ST_WAIT = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   pc_type      pc_ff, pc_in;
   logic [31:0] meas_ff, meas_in;
   logic [31:0] acc_ff, acc_in;
   logic [15:0] ts_ff, ts_in;
   logic [20:0] altin_ff, altin_in;
   wide_type    s_ff, s_in;
   word_type    alt_ff, alt_in, spd_ff, spd_in, pzz_ff, pzz_in, pzv_ff, pzv_in;
   word_type    pvv_ff, pvv_in;
   word_type    dt_ff, dt_in, qa_ff, qa_in, dt2_ff, dt2_in, dt3_ff, dt3_in;
   word_type    dt4_ff, dt4_in, t_ff, t_in, tmp_ff, tmp_in, r_ff, r_in, y_ff, y_in;
   word_type    kz_ff, kz_in, kv_ff, kv_in, altf_ff, altf_in, ofa_ff, ofa_in;
   word_type    ofv_ff, ofv_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   logic [55:0] rsp_tdata_ff, rsp_tdata_in;

   uop_type            u;
   word_type           va, vb, vb_sh, wr_data;
   logic               wr_en;
   logic               req_acc;
   logic               mul_start, div_start, mul_done, div_done;
   word_type           mul_p, div_q;
   logic [SHIFT_W-1:0] mul_sh;

   function automatic word_type pick(src_type s, word_type alt, word_type spd,
                                     word_type pzz, word_type pzv, word_type pvv,
                                     word_type dt, word_type qa, word_type dt2,
                                     word_type dt3, word_type dt4, word_type t,
                                     word_type tmp, word_type r, word_type y,
                                     word_type kz, word_type kv, word_type altf,
                                     word_type ofa, word_type ofv, logic [31:0] acc,
                                     logic [31:0] meas, logic [15:0] ts,
                                     logic [20:0] altin);
      word_type v;
      unique case (s)
         SRC_ALT:   v = alt;
         SRC_SPD:   v = spd;
         SRC_PZZ:   v = pzz;
         SRC_PZV:   v = pzv;
         SRC_PVV:   v = pvv;
         SRC_DT:    v = dt;
         SRC_QA:    v = qa;
         SRC_DT2:   v = dt2;
         SRC_DT3:   v = dt3;
         SRC_DT4:   v = dt4;
         SRC_T:     v = t;
         SRC_TMP:   v = tmp;
         SRC_R:     v = r;
         SRC_Y:     v = y;
         SRC_KZ:    v = kz;
         SRC_KV:    v = kv;
         SRC_ALTF:  v = altf;
         SRC_OFA:   v = ofa;
         SRC_OFV:   v = ofv;
         SRC_ACC:   v = word_type'({16'd0, acc});
         SRC_MEAS:  v = word_type'({16'd0, meas});
         SRC_TS:    v = word_type'({32'd0, ts});
         SRC_ALTIN: v = word_type'({{27{altin[20]}}, altin});
         SRC_ONE:   v = ONE_C;
         SRC_C256:  v = C256;
         default:   v = '0;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] clamp32(word_type x);
      if (x > word_type'(32'sh7FFFFFFF)) return 32'h7FFFFFFF;
      else if (x < -word_type'(33'sh080000000)) return 32'h80000000;
      else return x[31:0];
   endfunction

   function automatic logic [23:0] clamp24(word_type x);
      if (x > word_type'(24'sh7FFFFF)) return 24'h7FFFFF;
      else if (x < -word_type'(25'sh0800000)) return 24'h800000;
      else return x[23:0];
   endfunction

   akf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .op_a    (va),
      .op_b    (vb),
      .shift   (mul_sh),
      .done    (mul_done),
      .product (mul_p)
   );

   akf_div #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (va),
      .den      (s_ff),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      u  = uop(pc_ff);
      va = pick(u.a, alt_ff, spd_ff, pzz_ff, pzv_ff, pvv_ff, dt_ff, qa_ff, dt2_ff, dt3_ff,
                dt4_ff, t_ff, tmp_ff, r_ff, y_ff, kz_ff, kv_ff, altf_ff, ofa_ff, ofv_ff,
                acc_ff, meas_ff, ts_ff, altin_ff);
      vb = pick(u.b, alt_ff, spd_ff, pzz_ff, pzv_ff, pvv_ff, dt_ff, qa_ff, dt2_ff, dt3_ff,
                dt4_ff, t_ff, tmp_ff, r_ff, y_ff, kz_ff, kv_ff, altf_ff, ofa_ff, ofv_ff,
                acc_ff, meas_ff, ts_ff, altin_ff);
      vb_sh = vb >>> u.bsh;
      unique case (u.sh)
         SH_ZERO:    mul_sh = SHIFT_W'(0);
         SH_EIGHT:   mul_sh = SHIFT_W'(8);
         SH_SIXTEEN: mul_sh = SHIFT_W'(16);
         SH_FRAC:    mul_sh = SHIFT_W'(FRACTION_BITS);
         default:    mul_sh = SHIFT_W'(0);
      endcase

      req_acc    = req_tvalid && req_tready;
      mul_start  = (state_ff == ST_RUN) && (u.op == OP_MUL);
      div_start  = (state_ff == ST_RUN) && (u.op == OP_DIV);

      state_in      = state_ff;
      pc_in         = pc_ff;
      s_in          = s_ff;
      ts_in         = ts_ff;
      altin_in      = altin_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      wr_en         = 1'b0;
      wr_data       = '0;

      meas_in = meas_ff;
      acc_in  = acc_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MEAS_VAR:  meas_in = csr_wdata;
            CSR_ACCEL_VAR: acc_in  = csr_wdata;
            default:       meas_in = meas_ff;
         endcase
      end

      alt_in = alt_ff; spd_in = spd_ff; pzz_in = pzz_ff; pzv_in = pzv_ff; pvv_in = pvv_ff;
      dt_in = dt_ff; qa_in = qa_ff; dt2_in = dt2_ff; dt3_in = dt3_ff; dt4_in = dt4_ff;
      t_in = t_ff; tmp_in = tmp_ff; r_in = r_ff; y_in = y_ff; kz_in = kz_ff; kv_in = kv_ff;
      altf_in = altf_ff; ofa_in = ofa_ff; ofv_in = ofv_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               ts_in    = req_tdata[36:21];
               altin_in = req_tdata[20:0];
               priority if (req_tuser == CMD_RESET) begin
                  alt_in = word_type'({{27{req_tdata[20]}}, req_tdata[20:0]}) <<< FRACTION_BITS;
                  spd_in = '0;
                  pzz_in = VAR_RESET;
                  pzv_in = '0;
                  pvv_in = VAR_RESET;
               end else if (req_tuser == CMD_PREDICT) begin
                  pc_in    = PC_PREDICT;
                  state_in = ST_RUN;
               end else if (req_tuser == CMD_UPDATE) begin
                  pc_in    = PC_UPDATE;
                  state_in = ST_RUN;
               end else begin
                  // unused command: dropped
                  state_in = ST_IDLE;
               end
            end
         end
         ST_RUN: begin
            unique case (u.op)
               OP_MUL, OP_DIV: state_in = ST_WAIT;
               OP_ADD: begin
                  wr_en   = 1'b1;
                  wr_data = sat48(wide_type'(va) + wide_type'(vb_sh));
                  pc_in   = pc_ff + PC_W'(1);
               end
               OP_SUB: begin
                  wr_en   = 1'b1;
                  wr_data = sat48(wide_type'(va) - wide_type'(vb));
                  pc_in   = pc_ff + PC_W'(1);
               end
               OP_SUM: begin
                  // innovation variance, kept unsaturated as the divisor
                  s_in  = wide_type'(va) + wide_type'(vb);
                  pc_in = pc_ff + PC_W'(1);
               end
               OP_CHK: begin
                  if (s_ff[WORD_W] || s_ff == '0) pc_in = PC_OUTPUT;
                  else pc_in = pc_ff + PC_W'(1);
               end
               OP_EMIT: begin
                  if (!rsp_tvalid_ff || rsp_tready) begin
                     rsp_tdata_in  = {clamp24(ofv_ff), clamp32(ofa_ff)};
                     rsp_tvalid_in = 1'b1;
                     state_in      = ST_IDLE;
                  end
               end
               OP_END: state_in = ST_IDLE;
               default: state_in = ST_IDLE;
            endcase
         end
         ST_WAIT: begin
            if (mul_done || div_done) begin
               wr_en    = 1'b1;
               wr_data  = div_done ? div_q : mul_p;
               pc_in    = pc_ff + PC_W'(1);
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (wr_en) begin
         unique case (u.dst)
            SRC_ALT:  alt_in  = wr_data;
            SRC_SPD:  spd_in  = wr_data;
            SRC_PZZ:  pzz_in  = wr_data;
            SRC_PZV:  pzv_in  = wr_data;
            SRC_PVV:  pvv_in  = wr_data;
            SRC_DT:   dt_in   = wr_data;
            SRC_QA:   qa_in   = wr_data;
            SRC_DT2:  dt2_in  = wr_data;
            SRC_DT3:  dt3_in  = wr_data;
            SRC_DT4:  dt4_in  = wr_data;
            SRC_T:    t_in    = wr_data;
            SRC_TMP:  tmp_in  = wr_data;
            SRC_R:    r_in    = wr_data;
            SRC_Y:    y_in    = wr_data;
            SRC_KZ:   kz_in   = wr_data;
            SRC_KV:   kv_in   = wr_data;
            SRC_ALTF: altf_in = wr_data;
            SRC_OFA:  ofa_in  = wr_data;
            SRC_OFV:  ofv_in  = wr_data;
            default:  tmp_in  = tmp_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pc_ff         <= PC_PREDICT;
         rsp_tvalid_ff <= 1'b0;
         meas_ff       <= MEAS_VAR_RESET;
         acc_ff        <= ACCEL_VAR_RESET;
         alt_ff        <= '0;
         spd_ff        <= '0;
         pzz_ff        <= VAR_RESET;
         pzv_ff        <= '0;
         pvv_ff        <= VAR_RESET;
      end else begin
         state_ff      <= state_in;
         pc_ff         <= pc_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         meas_ff       <= meas_in;
         acc_ff        <= acc_in;
         alt_ff        <= alt_in;
         spd_ff        <= spd_in;
         pzz_ff        <= pzz_in;
         pzv_ff        <= pzv_in;
         pvv_ff        <= pvv_in;
      end
      s_ff         <= s_in;
      ts_ff        <= ts_in;
      altin_ff     <= altin_in;
      rsp_tdata_ff <= rsp_tdata_in;
      dt_ff   <= dt_in;
      qa_ff   <= qa_in;
      dt2_ff  <= dt2_in;
      dt3_ff  <= dt3_in;
      dt4_ff  <= dt4_in;
      t_ff    <= t_in;
      tmp_ff  <= tmp_in;
      r_ff    <= r_in;
      y_ff    <= y_in;
      kz_ff   <= kz_in;
      kv_ff   <= kv_in;
      altf_ff <= altf_in;
      ofa_ff  <= ofa_in;
      ofv_ff  <= ofv_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign csr_ready  = 1'b1;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench of the altitude and vertical speed filter: directed table, random commands, scoreboard
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import akf_pkg::*;

   localparam int FB = 16;
   localparam longint M48 = 64'h7FFF_FFFF_FFFF;
   localparam longint ONE_FX = 64'sd1 << FB;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [1:0]  req_tuser = CMD_PREDICT;
   logic [39:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = CSR_MEAS_VAR;
   logic [31:0] csr_wdata = '0;

   altitude_velocity_kalman_filter_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // filter model state
   longint unsigned meas_var, accel_var;
   longint alt_est, spd_est, p_zz, p_zv, p_vv;

   typedef struct {
      logic signed [31:0] alt;
      logic signed [23:0] spd;
   } estimate_t;
   estimate_t estimates_due[$];

   int mismatches = 0;
   int cycles = 0;
   int send_idle = 0, recv_stall = 0;

   function automatic longint sat(longint x);
      if (x > M48) return M48;
      if (x < -M48) return -M48;
      return x;
   endfunction

   // magnitude product shifted down, sign restored, saturated
   function automatic longint fx_mul(longint a, longint b, int sh);
      logic [127:0] p;
      longint unsigned ua, ub;
      logic [127:0] r;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = 128'(ua) * 128'(ub);
      r = p >> sh;
      if (r > 128'(M48)) r = 128'(M48);
      return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint fx_div(longint num, longint den);
      logic [127:0] q;
      longint unsigned un;
      un = num < 0 ? -num : num;
      q = (128'(un) << FB) / 128'(den);
      if (q > 128'(M48)) q = 128'(M48);
      return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint clip(longint x, longint lo, longint hi);
      return x < lo ? lo : (x > hi ? hi : x);
   endfunction

   task automatic model_reset();
      meas_var = MEAS_VAR_RESET;
      accel_var = ACCEL_VAR_RESET;
      alt_est = 0;
      spd_est = 0;
      p_zz = 1500 * ONE_FX;
      p_zv = 0;
      p_vv = 1500 * ONE_FX;
   endtask

   task automatic predict_filter(logic [1:0] cmd, logic [39:0] data);
      longint alt_in, dt, qa, dt2, dt3, dt4, t, zz, zv, r, s, y, kz, kv, zvo;
      estimate_t e;
      alt_in = longint'($signed(data[20:0])) * ONE_FX;
      if (cmd == CMD_RESET) begin
         alt_est = alt_in;
         spd_est = 0;
         p_zz = 1500 * ONE_FX;
         p_zv = 0;
         p_vv = 1500 * ONE_FX;
      end else if (cmd == CMD_PREDICT) begin
         dt = fx_mul(longint'(data[36:21]), ONE_FX, 16);
         qa = fx_mul(longint'(accel_var), ONE_FX, 8);
         dt2 = fx_mul(dt, dt, FB);
         dt3 = fx_mul(dt2, dt, FB);
         dt4 = fx_mul(dt2, dt2, FB);
         t = fx_mul(dt, p_zv, FB);
         alt_est = sat(alt_est + fx_mul(spd_est, dt, FB));
         zz = sat(p_zz + t);
         zz = sat(zz + t);
         zz = sat(zz + fx_mul(dt2, p_vv, FB));
         zz = sat(zz + fx_mul(qa, dt4, FB) / 4);
         zv = sat(p_zv + fx_mul(dt, p_vv, FB));
         zv = sat(zv + fx_mul(qa, dt3, FB) / 2);
         p_vv = sat(p_vv + fx_mul(qa, dt2, FB));
         p_zz = zz;
         p_zv = zv;
      end else if (cmd == CMD_UPDATE) begin
         r = fx_mul(longint'(meas_var), ONE_FX, 8);
         s = p_zz + r;
         // no correction when the innovation variance is not positive
         if (s > 0) begin
            y = sat(alt_in - alt_est);
            kz = fx_div(p_zz, s);
            kv = fx_div(p_zv, s);
            zvo = p_zv;
            alt_est = sat(alt_est + fx_mul(kz, y, FB));
            spd_est = sat(spd_est + fx_mul(kv, y, FB));
            p_vv = sat(p_vv - fx_mul(zvo, kv, FB));
            p_zv = sat(zvo - fx_mul(zvo, kz, FB));
            p_zz = sat(p_zz - fx_mul(p_zz, kz, FB));
         end
         e.alt = 32'(clip(fx_mul(alt_est, 256, FB), -64'sd2147483648, 64'sd2147483647));
         e.spd = 24'(clip(fx_mul(spd_est, 256, FB), -64'sd8388608, 64'sd8388607));
         estimates_due.push_back(e);
      end
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      estimate_t e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (estimates_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_tdata);
         end else begin
            e = estimates_due.pop_front();
            if (rsp_tdata[31:0] !== e.alt || rsp_tdata[55:32] !== e.spd) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected alt %0d spd %0d, got alt %0d spd %0d",
                           e.alt, e.spd, $signed(rsp_tdata[31:0]), $signed(rsp_tdata[55:32]));
            end
         end
      end
      rsp_tready <= ($urandom_range(99) >= recv_stall);
   end

   // valid stays up after an accept so the next item can follow at once
   task automatic send_item(logic [1:0] cmd, logic signed [20:0] alt, logic [15:0] ts);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b0, ts, alt};
      do @(posedge clock); while (!req_tready);
      predict_filter(cmd, {3'b0, ts, alt});
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (estimates_due.size() != 0) @(posedge clock);
      // a predict may still be running with no result pending
      repeat (400) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_MEAS_VAR) meas_var = val;
      else accel_var = val;
      @(posedge clock);
   endtask

   typedef struct {
      logic [1:0]         cmd;
      logic signed [20:0] alt;
      logic [15:0]        ts;
      bit                 known;
      logic signed [31:0] alt_out;
      logic signed [23:0] spd_out;
   } vector_t;

   vector_t directed[] = '{
      '{CMD_UPDATE,  21'sd0,       16'd0,     1'b1, 32'sd0, 24'sd0},
      '{CMD_RESET,   21'sd1000000, 16'd0,     1'b0, 0, 0},
      '{CMD_UPDATE,  21'sd1000000, 16'd0,     1'b1, 32'sd256000000, 24'sd0},
      '{CMD_RESET,   -21'sd100000, 16'd0,     1'b0, 0, 0},
      '{CMD_PREDICT, 21'sd0,       16'hFFFF,  1'b0, 0, 0},
      '{CMD_UPDATE,  -21'sd100000, 16'd0,     1'b0, 0, 0},
      '{CMD_PREDICT, 21'sd0,       16'd0,     1'b0, 0, 0},
      '{CMD_UPDATE,  21'sd1000000, 16'd0,     1'b0, 0, 0},
      '{CMD_UNUSED,  21'sd0,       16'hFFFF,  1'b0, 0, 0},
      '{CMD_PREDICT, 21'sd0,       16'd2621,  1'b0, 0, 0},
      '{CMD_UPDATE,  -21'sd1048576,16'd0,     1'b0, 0, 0},
      '{CMD_UPDATE,  21'sd1048575, 16'd0,     1'b0, 0, 0},
      '{CMD_RESET,   21'sd0,       16'd0,     1'b0, 0, 0}
   };

   task automatic random_phase(int count);
      int k;
      logic [1:0] cmd;
      logic signed [20:0] alt;
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(99);
         cmd = k < 45 ? CMD_PREDICT : (k < 92 ? CMD_UPDATE : (k < 97 ? CMD_RESET : CMD_UNUSED));
         alt = $urandom_range(9) == 0 ? 21'($urandom) :
               21'(longint'($urandom_range(1100000)) - 100000);
         send_item(cmd, alt, $urandom_range(3) == 0 ? 16'($urandom) :
                   16'($urandom_range(3000)));
      end
   endtask

   initial begin
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed[i]) begin
         send_item(directed[i].cmd, directed[i].alt, directed[i].ts);
         if (directed[i].known) begin
            estimates_due[$].alt = directed[i].alt_out;
            estimates_due[$].spd = directed[i].spd_out;
         end
      end
      drain();
      for (int ph = 0; ph < 6; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 47; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 47; end
            default: begin send_idle = 12; recv_stall = 12; end
         endcase
         case (ph)
            1: begin write_reg(CSR_MEAS_VAR, 32'd0); write_reg(CSR_ACCEL_VAR, 32'd0); end
            2: begin write_reg(CSR_MEAS_VAR, 32'hFFFF_FFFF);
                     write_reg(CSR_ACCEL_VAR, 32'hFFFF_FFFF); end
            3, 4: begin write_reg(CSR_MEAS_VAR, $urandom);
                        write_reg(CSR_ACCEL_VAR, $urandom_range(1000000)); end
            5: begin write_reg(CSR_MEAS_VAR, MEAS_VAR_RESET);
                     write_reg(CSR_ACCEL_VAR, ACCEL_VAR_RESET); end
            default: ;
         endcase
         random_phase(300);
         drain();
      end
      if (mismatches == 0 && estimates_due.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/akf_pkg.sv
rtl/akf_mul.sv
rtl/akf_div.sv
rtl/altitude_velocity_kalman_filter_unit.sv
tb/sv/tb_top.sv
